### src/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Types and constants shared by the swap slot stack allocator modules.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int SLOT_W   = 10;
	localparam int SECTOR_W = 13;
	localparam int CNT_W    = 11;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_NONE_USED = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_number;
		logic [SECTOR_W-1:0] sector;
		logic                last;
		status_t             status;
	} rsp_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] slot;
		status_t          status;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

endpackage

### src/ssa_ram.sv
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/ssa_queue.sv
// ----------------------------------------------------------------------------
// ssa_queue
// Two-entry request queue between the classifying front and the sector
// sequencer.
// ----------------------------------------------------------------------------
module ssa_queue import ssa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_push_t wr,
	output logic      full,
	output logic      head_valid,
	output job_t      head,
	input  logic      pop
);

	job_t        ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			ent_q[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/ssa_front.sv
// ----------------------------------------------------------------------------
// ssa_front
// Accepts requests, checks them against the free-slot stack and performs the
// push or pop; hands each classified request to the queue.
// ----------------------------------------------------------------------------
module ssa_front import ssa_pkg::*; #(
	parameter int SLOT_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	input  logic [CNT_W-1:0] slot_count,
	input  logic             q_full,
	output job_push_t        q_wr
);

	localparam int TOP_W  = $clog2(SLOT_DEPTH + 1);
	localparam int ADDR_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int EXT_W  = (TOP_W > CNT_W) ? TOP_W : CNT_W;

	typedef enum logic {
		FR_IDLE,
		FR_READ
	} fr_state_t;

	fr_state_t         state_q;
	logic [TOP_W-1:0]  top_q;
	logic [TOP_W-1:0]  hw_q;
	logic              fresh_q;
	logic [CNT_W-1:0]  fresh_slot_q;

	logic [EXT_W-1:0]  cnt_ext;
	logic [EXT_W-1:0]  depth_ext;
	logic [EXT_W-1:0]  eff_cnt;
	logic [EXT_W-1:0]  top_ext;
	logic [EXT_W-1:0]  slot_ext;
	logic              accept;
	logic              alloc_fail;
	logic              range_fail;
	logic              none_fail;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [SLOT_W-1:0] mem_rdata;

	assign cnt_ext    = EXT_W'(slot_count);
	assign depth_ext  = EXT_W'(SLOT_DEPTH);
	assign eff_cnt    = (cnt_ext > depth_ext) ? depth_ext : cnt_ext;
	assign top_ext    = EXT_W'(top_q);
	assign slot_ext   = EXT_W'(cmd.slot);

	assign cmd_stall  = (state_q != FR_IDLE) || q_full;
	assign accept     = cmd_valid && !cmd_stall;

	assign alloc_fail = (top_ext >= eff_cnt);
	assign range_fail = (slot_ext >= eff_cnt);
	assign none_fail  = (top_q == '0);

	assign mem_we     = accept && (cmd.command == CMD_FREE) && !range_fail && !none_fail;
	assign mem_waddr  = ADDR_W'(top_q - TOP_W'(1));
	assign mem_raddr  = ADDR_W'(top_q);

	ssa_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (cmd.slot),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		q_wr.push       = 1'b0;
		q_wr.job.slot   = '0;
		q_wr.job.status = ST_OK;
		case (state_q)
			FR_IDLE: begin
				if (accept) begin
					if (cmd.command == CMD_ALLOC) begin
						if (alloc_fail) begin
							q_wr.push       = 1'b1;
							q_wr.job.status = ST_NO_FREE;
						end
					end else begin
						q_wr.push     = 1'b1;
						q_wr.job.slot = CNT_W'(cmd.slot);
						if (range_fail) begin
							q_wr.job.status = ST_RANGE;
						end else if (none_fail) begin
							q_wr.job.status = ST_NONE_USED;
						end
					end
				end
			end
			FR_READ: begin
				q_wr.push     = 1'b1;
				q_wr.job.slot = fresh_q ? fresh_slot_q : CNT_W'(mem_rdata);
			end
			default: begin
				q_wr.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FR_IDLE;
			top_q        <= '0;
			hw_q         <= '0;
			fresh_q      <= 1'b0;
			fresh_slot_q <= '0;
		end else begin
			case (state_q)
				FR_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_ALLOC) begin
							if (!alloc_fail) begin
								// entries at or above the high-water mark still hold their index
								fresh_q      <= (top_q == hw_q);
								fresh_slot_q <= top_ext[CNT_W-1:0];
								top_q        <= top_q + TOP_W'(1);
								if (top_q == hw_q) begin
									hw_q <= hw_q + TOP_W'(1);
								end
								state_q <= FR_READ;
							end
						end else if (mem_we) begin
							top_q <= top_q - TOP_W'(1);
						end
					end
				end
				FR_READ: begin
					state_q <= FR_IDLE;
				end
				default: begin
					state_q <= FR_IDLE;
				end
			endcase
		end
	end

endmodule

### src/ssa_back.sv
// ----------------------------------------------------------------------------
// ssa_back
// Sector sequencer: turns each queued request into its run of sector
// results, one per cycle unless stalled, through an output register.
// ----------------------------------------------------------------------------
module ssa_back import ssa_pkg::*; #(
	parameter int SECTORS_PER_SLOT = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_head,
	output logic q_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
	localparam int SPS_W  = $clog2(SECTORS_PER_SLOT + 1);
	localparam int PROD_W = (CNT_W + SPS_W > SECTOR_W) ? CNT_W + SPS_W : SECTOR_W;

	logic                busy_q;
	logic [SLOT_W-1:0]   slot_q;
	status_t             status_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [IDX_W-1:0]    idx_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                advance;
	logic                last_now;
	logic                load_slot;
	logic [PROD_W-1:0]   base;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign last_now  = (status_q != ST_OK) || (idx_q == IDX_W'(SECTORS_PER_SLOT - 1));
	assign load_slot = advance && (!busy_q || last_now);
	assign q_pop     = load_slot && q_valid;
	assign base      = PROD_W'(q_head.slot) * PROD_W'(SECTORS_PER_SLOT);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			rsp_q.slot_number <= slot_q;
			rsp_q.sector      <= sector_q;
			rsp_q.last        <= last_now;
			rsp_q.status      <= status_q;
		end
		if (q_pop) begin
			slot_q   <= q_head.slot[SLOT_W-1:0];
			status_q <= q_head.status;
			sector_q <= (q_head.status == ST_OK) ? base[SECTOR_W-1:0] : '0;
		end else if (advance && busy_q) begin
			sector_q <= sector_q + SECTOR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && busy_q) begin
				if (last_now) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

### src/swap_slot_stack_allocator.sv
// Swap slot allocator built around a stack of free slot numbers. An allocate
// request pops the top free slot and a free request pushes the given slot
// back; either one then yields SECTORS_PER_SLOT results, one sector address
// per cycle when not stalled, with last set on the final one. A rejected
// request yields a single result carrying its error status and leaves the
// stack untouched. The front handles an allocate in FR_IDLE and then
// FR_READ (registered stack read), and a free or a rejected request in
// FR_IDLE alone; the sector sequencer emits one result per cycle unless
// rsp_stall holds its output register. A two-entry queue between front
// and sequencer lets the front run ahead. No clearing pass is needed after
// reset: a high-water mark tracks which stack entries were ever touched,
// and untouched entries read as their index. slot_count may only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
// swap_slot_stack_allocator
// Top level: configuration register, front, request queue and sequencer.
// ----------------------------------------------------------------------------
module swap_slot_stack_allocator import ssa_pkg::*; #(
	parameter int SLOT_DEPTH       = 1024,
	parameter int SECTORS_PER_SLOT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	logic [CNT_W-1:0] slot_count_q;
	job_push_t        q_wr;
	logic             q_full;
	logic             q_valid;
	job_t             q_head;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	ssa_front #(
		.SLOT_DEPTH (SLOT_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.slot_count (slot_count_q),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	ssa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (q_wr),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	ssa_back #(
		.SECTORS_PER_SLOT (SECTORS_PER_SLOT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
